// ===== hw/rtl/scfla_pkg.sv =====
package scfla_pkg;

    // Defaults for the top-level parameters.
    localparam int POOL_PAGES_DEF = 16;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int MAX_CLASS_DEF  = 12;

    // Fixed geometry: 16-bit byte addresses and one link cell per 64 bytes.
    localparam int MIN_CLASS    = 6;
    localparam int ADDR_W       = 16;
    localparam int HEAD_W       = 17;
    localparam int CELL_SHIFT   = 6;
    localparam int LINK_AW      = ADDR_W - CELL_SHIFT;
    localparam int LINK_DEPTH   = 1 << LINK_AW;
    localparam int ADDR_SPACE   = 1 << ADDR_W;
    localparam logic [HEAD_W-1:0] NULL_PTR = 17'h1FFFF;

    // Configuration register.
    localparam int PAGE_LIMIT_W = 5;
    localparam logic [PAGE_LIMIT_W-1:0] PAGE_LIMIT_RST = 5'd16;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam logic REG_PAGE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_TOO_LARGE = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    free_push;
        logic    carve_start;
        logic    carve_push;
        logic    pop_read;
        logic    pop_commit;
        logic    emit;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic too_large;
        logic is_free;
        logic head_null;
        logic can_carve;
        logic carve_empty;
        logic carve_last;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/scfla_datapath.sv =====
module scfla_datapath #(
    parameter int POOL_PAGES = scfla_pkg::POOL_PAGES_DEF,
    parameter int PAGE_BYTES = scfla_pkg::PAGE_BYTES_DEF,
    parameter int MAX_CLASS  = scfla_pkg::MAX_CLASS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_opcode,
    input  logic [scfla_pkg::ADDR_W-1:0]       i_size_bytes,
    input  logic [scfla_pkg::ADDR_W-1:0]       i_block_address,
    input  logic [scfla_pkg::PAGE_LIMIT_W-1:0] i_page_limit,
    input  scfla_pkg::t_cmd                    i_cmd,
    output scfla_pkg::t_stat                   o_stat,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [1:0]                         o_status,
    output logic [scfla_pkg::ADDR_W-1:0]       o_address
);
    import scfla_pkg::*;

    localparam int NUM_CLASSES = MAX_CLASS - MIN_CLASS + 1;
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int PU_W        = $clog2(POOL_PAGES + 1);
    localparam int CMP_W       = (PU_W > PAGE_LIMIT_W) ? PU_W : PAGE_LIMIT_W;
    localparam int FIT_PAGES   = ADDR_SPACE / PAGE_BYTES;
    localparam int CAP_STATIC  = (POOL_PAGES < FIT_PAGES) ? POOL_PAGES : FIT_PAGES;
    localparam int HALF_PAGE   = PAGE_BYTES / 2;
    localparam int BLK_W       = $clog2((PAGE_BYTES >> MIN_CLASS) + 1);

    // Latched request.
    logic                   r_op;
    logic                   r_large;
    logic [CLS_W-1:0]       r_class;
    logic [ADDR_W-1:0]      r_addr;
    logic [CLS_W-1:0]       n_class;
    logic                   n_large;

    logic [HEAD_W-1:0]      r_head [NUM_CLASSES];
    logic [PU_W-1:0]        r_pages_used;
    logic [ADDR_W-1:0]      r_page_base;
    logic [ADDR_W-1:0]      r_carve_addr;
    logic [BLK_W-1:0]       r_carve_left;

    logic [HEAD_W-1:0]      r_link_mem [LINK_DEPTH];
    logic [HEAD_W-1:0]      r_link_rdata;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [ADDR_W-1:0]      r_out_address;

    logic [HEAD_W-1:0]      head_cur;
    logic [CMP_W-1:0]       cap_now;
    logic                   can_carve;
    logic [4:0]             blk_log2;
    logic [HEAD_W-1:0]      blk_size;
    logic [HEAD_W-1:0]      blk_count_full;
    logic [BLK_W-1:0]       blk_count;
    logic                   link_we;
    logic [LINK_AW-1:0]     link_waddr;
    logic                   head_we;
    logic [HEAD_W-1:0]      n_head;
    logic                   out_free;

    // Size class: smallest power of two at or above the size, clamped to the
    // class range. Scanning downward leaves the smallest match.
    always_comb begin
        n_class = CLS_W'(MAX_CLASS - MIN_CLASS);
        for (int b = MAX_CLASS; b >= MIN_CLASS; b--) begin
            if ({1'b0, i_size_bytes} <= (17'(1) << b)) begin
                n_class = CLS_W'(b - MIN_CLASS);
            end
        end
    end

    assign n_large = ({1'b0, i_size_bytes} > 17'(HALF_PAGE));

    assign head_cur = r_head[r_class];

    assign cap_now   = (CMP_W'(i_page_limit) < CMP_W'(CAP_STATIC)) ?
                       CMP_W'(i_page_limit) : CMP_W'(CAP_STATIC);
    assign can_carve = (CMP_W'(r_pages_used) < cap_now);

    assign blk_log2       = 5'(r_class) + 5'(MIN_CLASS);
    assign blk_size       = 17'(1) << blk_log2;
    assign blk_count_full = 17'(PAGE_BYTES) >> blk_log2;
    assign blk_count      = BLK_W'(blk_count_full);

    assign link_we    = i_cmd.free_push | i_cmd.carve_push;
    assign link_waddr = i_cmd.free_push ? r_addr[ADDR_W-1:CELL_SHIFT]
                                        : r_carve_addr[ADDR_W-1:CELL_SHIFT];

    always_comb begin
        head_we = 1'b1;
        n_head  = head_cur;
        if (i_cmd.free_push) begin
            n_head = {1'b0, r_addr};
        end else if (i_cmd.carve_push) begin
            n_head = {1'b0, r_carve_addr};
        end else if (i_cmd.pop_commit) begin
            n_head = r_link_rdata;
        end else begin
            head_we = 1'b0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_large <= n_large;
            r_class <= n_class;
            r_addr  <= i_block_address;
        end
        if (i_cmd.carve_start) begin
            r_carve_addr <= r_page_base;
            r_carve_left <= blk_count;
        end else if (i_cmd.carve_push) begin
            r_carve_addr <= r_carve_addr + blk_size[ADDR_W-1:0];
            r_carve_left <= r_carve_left - BLK_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_status  <= i_cmd.status;
            r_out_address <= i_cmd.pop_commit ? head_cur[ADDR_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= NULL_PTR;
            end
            r_pages_used <= '0;
            r_page_base  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (head_we) begin
                r_head[r_class] <= n_head;
            end
            if (i_cmd.carve_start) begin
                r_pages_used <= r_pages_used + PU_W'(1);
                r_page_base  <= r_page_base + ADDR_W'(PAGE_BYTES);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Link store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= head_cur;
        end
        if (i_cmd.pop_read) begin
            r_link_rdata <= r_link_mem[head_cur[ADDR_W-1:CELL_SHIFT]];
        end
    end

    assign o_stat.too_large   = r_large;
    assign o_stat.is_free     = (r_op == OP_FREE);
    assign o_stat.head_null   = (head_cur == NULL_PTR);
    assign o_stat.can_carve   = can_carve;
    assign o_stat.carve_empty = (blk_count == '0);
    assign o_stat.carve_last  = (r_carve_left == BLK_W'(1));
    assign o_stat.out_free    = out_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_address   = r_out_address;

endmodule

// ===== hw/rtl/scfla_ctrl.sv =====
module scfla_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  scfla_pkg::t_stat i_stat,
    output scfla_pkg::t_cmd  o_cmd
);
    import scfla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_CARVE,
        S_POP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                // Nothing changes until the output register can take a result.
                if (i_stat.out_free) begin
                    if (i_stat.too_large) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_TOO_LARGE;
                        n_state      = S_IDLE;
                    end else if (i_stat.is_free) begin
                        o_cmd.free_push = 1'b1;
                        o_cmd.emit      = 1'b1;
                        n_state         = S_IDLE;
                    end else if (!i_stat.head_null) begin
                        o_cmd.pop_read = 1'b1;
                        n_state        = S_POP;
                    end else if (!i_stat.can_carve) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_OOM;
                        n_state      = S_IDLE;
                    end else if (i_stat.carve_empty) begin
                        // The page is used up even though it yields no block.
                        o_cmd.carve_start = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.status      = ST_OOM;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.carve_start = 1'b1;
                        n_state           = S_CARVE;
                    end
                end
            end
            S_CARVE: begin
                o_cmd.carve_push = 1'b1;
                if (i_stat.carve_last) begin
                    n_state = S_DECODE;
                end
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_commit = 1'b1;
                    o_cmd.emit       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result issued while the output register is occupied");

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.free_push, o_cmd.carve_start, o_cmd.carve_push,
                  o_cmd.pop_read, o_cmd.pop_commit}))
        else $error("more than one list update in a cycle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop_read |-> !i_stat.head_null)
        else $error("pop issued on an empty class list");

    a_pop_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pop_read) |=> (r_state == S_POP))
        else $error("link read not followed by the pop state");

endmodule

// ===== hw/rtl/size_class_free_list_allocator.sv =====
// Size-class free-list allocator for sub-page objects.
// Request channel: i_in_valid / o_in_stall with i_opcode (0 allocate, 1 free),
// i_size_bytes and i_block_address. A transaction is taken on a rising edge
// with i_in_valid high and o_in_stall low. Result channel: o_out_valid /
// i_out_stall with o_status (0 ok, 1 out of memory, 2 too large) and
// o_address; exactly one result per request, in request order.
// The controller works on one request at a time. A free or a rejected request
// is loaded in the idle state and answered from the decode state; an allocate
// from a non-empty list also passes through the pop state for the registered
// read of the link store. An allocate that must carve a fresh page pushes
// every block in the page (PAGE_BYTES >> class, at most 64 with a 4 KiB page)
// onto its class list in the carve state, one link store write per cycle.
// The result sits in an output register, so a new request is taken while a
// finished result waits; when the receiver stalls and the next result is
// ready, the controller holds it internally and o_in_stall stays high.
// Reset empties all class lists, clears the page count and sets page_limit
// to 16. The link store needs no clearing; page_limit is the APB register
// at offset 0 and should be written only while the block is idle.
module size_class_free_list_allocator #(
    parameter int POOL_PAGES = scfla_pkg::POOL_PAGES_DEF,
    parameter int PAGE_BYTES = scfla_pkg::PAGE_BYTES_DEF,
    parameter int MAX_CLASS  = scfla_pkg::MAX_CLASS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [15:0]                  i_size_bytes,
    input  logic [15:0]                  i_block_address,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [15:0]                  o_address,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scfla_pkg::APB_AW-1:0] paddr,
    input  logic [scfla_pkg::APB_DW-1:0] pwdata,
    output logic [scfla_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import scfla_pkg::*;

    logic [PAGE_LIMIT_W-1:0] r_page_limit;
    logic                    cfg_write;
    logic                    reg_sel;
    t_cmd                    cmd;
    t_stat                   stat;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[APB_AW-1] == REG_PAGE_LIMIT);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_limit <= PAGE_LIMIT_RST;
        end else if (cfg_write && reg_sel) begin
            r_page_limit <= pwdata[PAGE_LIMIT_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DW'(r_page_limit) : '0;

    scfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scfla_datapath #(
        .POOL_PAGES (POOL_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_CLASS  (MAX_CLASS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_opcode),
        .i_size_bytes    (i_size_bytes),
        .i_block_address (i_block_address),
        .i_page_limit    (r_page_limit),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_address       (o_address)
    );

endmodule

// ===== verif/size_class_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps

module size_class_free_list_allocator_tb;
    import scfla_pkg::*;

    localparam int PAGE_BYTES  = PAGE_BYTES_DEF;
    localparam int NUM_CLASSES = MAX_CLASS_DEF - MIN_CLASS + 1;

    typedef struct {
        t_status     status;
        logic [15:0] address;
    } t_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_opcode;
    logic [15:0]        i_size_bytes;
    logic [15:0]        i_block_address;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [15:0]        o_address;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Allocator state as the testbench sees it.
    logic [HEAD_W-1:0]       class_head [NUM_CLASSES];
    logic [HEAD_W-1:0]       link_cell [LINK_DEPTH];
    int                      pages_carved;
    int                      page_limit_model;

    t_reply                  due_replies [$];
    logic [15:0]             live_addr [$];
    int                      live_class [$];

    int error_count;
    int traffic_mode;
    int stall_left;
    int n_requests, n_grants, n_oom, n_too_large, n_frees;

    size_class_free_list_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_size_bytes    (i_size_bytes),
        .i_block_address (i_block_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_address       (o_address),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (traffic_mode == 0 || $urandom_range(0, 99) < 70) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= 1'b1;
            stall_left  <= pick_idle_len() - 1;
        end
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_replies.size() == 0) begin
                $display("%0t: unexpected result status %0d address %h",
                         $time, o_status, o_address);
                error_count++;
            end else begin
                want = due_replies.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_address !== want.address) begin
                    $display("%0t: address mismatch expected %h actual %h",
                             $time, want.address, o_address);
                    error_count++;
                end
            end
        end
    end

    function automatic int size_to_class(logic [15:0] size);
        int c;
        c = MIN_CLASS;
        while (c < MAX_CLASS_DEF && (32'd1 << c) < size) begin
            c++;
        end
        return c;
    endfunction

    function automatic logic [15:0] size_in_class(int c);
        if (c == MIN_CLASS) begin
            return 16'($urandom_range(0, 64));
        end
        return 16'($urandom_range((1 << (c - 1)) + 1, 1 << c));
    endfunction

    function automatic void push_block(int ci, logic [15:0] addr);
        link_cell[addr >> CELL_SHIFT] = class_head[ci];
        class_head[ci] = {1'b0, addr};
    endfunction

    task automatic predict_request(t_opcode op, logic [15:0] size, logic [15:0] addr);
        t_reply      r;
        int          cls, ci, cap, span, q, base;
        logic [15:0] h;
        r.status  = ST_OK;
        r.address = '0;
        n_requests++;
        if (size > PAGE_BYTES / 2) begin
            r.status = ST_TOO_LARGE;
            n_too_large++;
        end else begin
            cls = size_to_class(size);
            ci  = cls - MIN_CLASS;
            if (op == OP_FREE) begin
                push_block(ci, addr);
                n_frees++;
            end else begin
                if (class_head[ci] == NULL_PTR) begin
                    cap = POOL_PAGES_DEF;
                    if (ADDR_SPACE / PAGE_BYTES < cap) begin
                        cap = ADDR_SPACE / PAGE_BYTES;
                    end
                    if (page_limit_model < cap) begin
                        cap = page_limit_model;
                    end
                    if (pages_carved < cap) begin
                        base = pages_carved * PAGE_BYTES;
                        pages_carved++;
                        span = 1 << cls;
                        for (q = 0; q + span <= PAGE_BYTES; q += span) begin
                            push_block(ci, 16'(base + q));
                        end
                    end
                end
                if (class_head[ci] == NULL_PTR) begin
                    r.status = ST_OOM;
                    n_oom++;
                end else begin
                    h = class_head[ci][15:0];
                    class_head[ci] = link_cell[h >> CELL_SHIFT] & NULL_PTR;
                    r.address = h;
                    live_addr.push_back(h);
                    live_class.push_back(cls);
                    n_grants++;
                end
            end
        end
        due_replies.push_back(r);
    endtask

    // Sends one request; valid stays high after acceptance until the next call
    // or a drain decides otherwise at the following falling edge.
    task automatic send_request(t_opcode op, logic [15:0] size, logic [15:0] addr);
        int gap;
        gap = 0;
        if (traffic_mode != 0 && $urandom_range(0, 99) >= 50) begin
            gap = pick_idle_len();
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_opcode        = op;
        i_size_bytes    = size;
        i_block_address = addr;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_request(op, size, addr);
    endtask

    task automatic free_newest();
        int idx;
        idx = live_addr.size() - 1;
        send_request(OP_FREE, size_in_class(live_class[idx]), live_addr[idx]);
        live_addr.delete(idx);
        live_class.delete(idx);
    endtask

    task automatic drain_replies();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (due_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Writes page_limit through the APB port while idle, then reads it back.
    task automatic write_page_limit(int value);
        drain_replies();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(REG_PAGE_LIMIT) << 2;
        pwdata  = APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        page_limit_model = value;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (prdata !== APB_DW'(value)) begin
            $display("%0t: page_limit readback mismatch expected %0d actual %0d",
                     $time, value, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // One carved page only: size extremes, both rejections, reuse, stray frees.
    task automatic test_single_page();
        traffic_mode = 0;
        write_page_limit(1);
        send_request(OP_ALLOC, 16'd0, 16'h0000);
        send_request(OP_ALLOC, 16'd64, 16'hFFFF);
        send_request(OP_ALLOC, 16'd65, 16'h0000);
        send_request(OP_ALLOC, 16'd2048, 16'h0000);
        send_request(OP_ALLOC, 16'd2049, 16'h0000);
        send_request(OP_FREE, 16'hFFFF, 16'hFFFF);
        send_request(OP_FREE, 16'd64, 16'h0FC0);
        send_request(OP_ALLOC, 16'd1, 16'h0000);
        // A free of an address that was never handed out is taken as given.
        send_request(OP_FREE, 16'd2048, 16'hFFFF);
        send_request(OP_ALLOC, 16'd1025, 16'h0000);
        send_request(OP_ALLOC, 16'd2048, 16'h0000);
        send_request(OP_FREE, 16'd100, 16'hABCD);
        send_request(OP_ALLOC, 16'd128, 16'h5432);
    endtask

    // Carves one page for every larger class until the limit is hit.
    task automatic test_class_sweep();
        traffic_mode = 1;
        write_page_limit(6);
        send_request(OP_ALLOC, 16'd128, 16'h0000);
        send_request(OP_ALLOC, 16'd256, 16'h0000);
        send_request(OP_ALLOC, 16'd512, 16'h0000);
        send_request(OP_ALLOC, 16'd1024, 16'h0000);
        send_request(OP_ALLOC, 16'd2048, 16'h0000);
        send_request(OP_ALLOC, 16'd1500, 16'h0000);
        send_request(OP_ALLOC, 16'd2000, 16'h0000);
        free_newest();
        send_request(OP_ALLOC, 16'd1100, 16'h0000);
        send_request(OP_ALLOC, 16'd33, 16'h0000);
    endtask

    // Mostly allocate and free of live blocks, with some rejected and stray requests.
    task automatic test_random_traffic(int limit, int count, int mode);
        int          i, r, idx, c;
        logic [15:0] a;
        write_page_limit(limit);
        traffic_mode = mode;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (i % 97 == 50) begin
                drain_replies();
            end
            if (live_addr.size() > 0 && (r < 40 || (live_addr.size() > 48 && r < 70))) begin
                idx = $urandom_range(0, live_addr.size() - 1);
                a   = live_addr[idx];
                c   = live_class[idx];
                live_addr.delete(idx);
                live_class.delete(idx);
                send_request(OP_FREE, size_in_class(c), a);
            end else if (r < 88) begin
                c = $urandom_range(MIN_CLASS, MAX_CLASS_DEF - 1);
                send_request(OP_ALLOC, size_in_class(c), 16'($urandom()));
            end else if (r < 94) begin
                send_request(t_opcode'($urandom_range(0, 1)),
                             16'($urandom_range(PAGE_BYTES / 2 + 1, 65535)),
                             16'($urandom()));
            end else if (r < 98) begin
                send_request(t_opcode'($urandom_range(0, 1)), 16'($urandom()),
                             16'($urandom()));
            end else begin
                send_request(OP_FREE, 16'($urandom_range(0, PAGE_BYTES / 2)),
                             16'($urandom()));
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_opcode        = 1'b0;
        i_size_bytes    = '0;
        i_block_address = '0;
        i_out_stall     = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        error_count     = 0;
        traffic_mode    = 0;
        stall_left      = 0;
        n_requests      = 0;
        n_grants        = 0;
        n_oom           = 0;
        n_too_large     = 0;
        n_frees         = 0;
        pages_carved    = 0;
        page_limit_model = PAGE_LIMIT_RST;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            class_head[k] = NULL_PTR;
        end
        for (int k = 0; k < LINK_DEPTH; k++) begin
            link_cell[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_page();
        test_class_sweep();
        test_random_traffic(10, 250, 0);
        test_random_traffic(16, 350, 1);
        test_random_traffic(3, 200, 1);

        drain_replies();
        repeat (20) @(posedge i_clk);
        $display("summary: %0d requests, %0d granted, %0d out of memory, %0d too large, %0d frees",
                 n_requests, n_grants, n_oom, n_too_large, n_frees);
        $display("summary: page limits 1, 6, 10, 16 and 3; %0d pages carved", pages_carved);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
